### design/lld_pkg.sv
`default_nettype none
package lld_pkg;

  localparam int CMD_W = 3;
  localparam int WID_W = 4;
  localparam int CLI_W = 16;
  localparam int TAG_W = 8;
  localparam int QSZ_W = 9;
  localparam int ERR_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ONLINE   = 3'd0,
    CMD_DISPATCH = 3'd1,
    CMD_COMPLETE = 3'd2,
    CMD_DISABLE  = 3'd3,
    CMD_REBORN   = 3'd4,
    CMD_POLL     = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_DISPATCHED = 3'd0,
    KIND_COMPLETED  = 3'd1,
    KIND_STAT       = 3'd2,
    KIND_KILL       = 3'd3,
    KIND_POLL_END   = 3'd4,
    KIND_ERROR      = 3'd5
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_WORKER = 3'd1,
    ERR_TAG_BUSY  = 3'd2,
    ERR_BAD_TAG   = 3'd3,
    ERR_BAD_REBORN = 3'd4
  } err_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [WID_W-1:0] worker_id;
    logic [CLI_W-1:0] client_id;
    logic [TAG_W-1:0] request_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [WID_W-1:0] worker_id_out;
    logic [TAG_W-1:0] tag_out;
    logic [CLI_W-1:0] client_out;
    logic [QSZ_W-1:0] queue_size;
    logic [ERR_W-1:0] error_code;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT,
    ST_POLL_STAT,
    ST_POLL_KILL,
    ST_POLL_END
  } state_t;

  typedef struct packed {
    logic load;
    logic search_start;
    logic exec;
    logic scan_clear;
    logic scan_step;
    logic scan_kill;
    logic emit_stat;
    logic emit_kill;
    logic emit_end;
  } ctl_t;

  typedef struct packed {
    logic search_done;
    logic scan_done;
    logic scan_hit;
    logic res_pending;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### design/lld_ram.sv
`default_nettype none
module lld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

### design/lld_datapath.sv
`default_nettype none
module lld_datapath import lld_pkg::*; #(
  parameter int MAX_WORKERS = 16,
  parameter int TAG_SLOTS   = 256,
  parameter int CLIENT_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_item,
  input  wire ctl_t      ctl,
  output sts_t           sts,
  input  wire logic      out_stall,
  output logic           out_valid,
  output out_item_t      out_item
);
  localparam int WI = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int TI = $clog2(TAG_SLOTS);
  localparam int SC = $clog2(MAX_WORKERS + 1);
  localparam logic [QSZ_W-1:0] CNT_MAX = '1;

  logic [MAX_WORKERS-1:0] online_r, active_r, drain_r;
  logic [QSZ_W-1:0]       cnt_r [MAX_WORKERS];
  logic [TAG_SLOTS-1:0]   tvalid_r;
  logic [TI-1:0]          ntag_r;
  in_item_t               req_r;
  logic [SC-1:0]          idx_r;
  logic                   best_ok_r;
  logic [WI-1:0]          best_r;
  logic                   res_r;
  out_item_t              res_item_r;
  logic                   ov_r;
  out_item_t              oi_r;

  logic              wok;
  logic [WI-1:0]     wsel;
  logic [TI-1:0]     rtag;
  logic              rtag_ok;
  logic [WI-1:0]     idx_w;
  logic              tag_wr;
  logic [CLI_W-1:0]  rd_client;
  logic [WID_W-1:0]  rd_owner;
  logic [CLI_W-1:0]  cli_masked;

  assign wok = ({{(32-WID_W){1'b0}}, req_r.worker_id} < MAX_WORKERS);
  assign wsel = WI'(req_r.worker_id);
  assign rtag = TI'(req_r.request_tag);
  assign rtag_ok = ({{(32-TAG_W){1'b0}}, req_r.request_tag} < TAG_SLOTS);
  assign idx_w = WI'(idx_r);
  assign cli_masked = CLI_W'(req_r.client_id & CLI_W'((64'd1 << CLIENT_BITS) - 64'd1));

  assign tag_wr = ctl.exec && req_r.command == CMD_DISPATCH && best_ok_r
                  && !tvalid_r[ntag_r];

  lld_ram #(.WIDTH(CLI_W), .DEPTH(TAG_SLOTS)) u_client (
    .clk(clk), .wr_en(tag_wr), .wr_addr(ntag_r), .wr_data(cli_masked),
    .rd_addr(rtag), .rd_data(rd_client)
  );
  lld_ram #(.WIDTH(WID_W), .DEPTH(TAG_SLOTS)) u_owner (
    .clk(clk), .wr_en(tag_wr), .wr_addr(ntag_r), .wr_data(WID_W'(best_r)),
    .rd_addr(rtag), .rd_data(rd_owner)
  );

  assign sts.search_done = (idx_r == SC'(MAX_WORKERS));
  assign sts.scan_done   = (idx_r == SC'(MAX_WORKERS));
  assign sts.scan_hit    = ctl.scan_kill
                           ? (drain_r[idx_w] && cnt_r[idx_w] == '0)
                           : active_r[idx_w];
  assign sts.res_pending = res_r;
  assign sts.out_free    = !ov_r || !out_stall;

  assign out_valid = ov_r;
  assign out_item  = oi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (!ov_r || !out_stall) begin
      ov_r <= 1'b0;
      if (res_r) begin
        ov_r <= 1'b1;
        oi_r <= res_item_r;
      end else if (ctl.emit_stat || ctl.emit_kill || ctl.emit_end) begin
        ov_r <= 1'b1;
        oi_r <= '0;
        if (ctl.emit_stat) begin
          oi_r.kind          <= KIND_STAT;
          oi_r.worker_id_out <= WID_W'(idx_r);
          oi_r.queue_size    <= cnt_r[idx_w];
        end else if (ctl.emit_kill) begin
          oi_r.kind          <= KIND_KILL;
          oi_r.worker_id_out <= WID_W'(idx_r);
        end else begin
          oi_r.kind <= KIND_POLL_END;
          oi_r.last <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_r <= '0;
      active_r <= '0;
      drain_r  <= '0;
      tvalid_r <= '0;
      ntag_r   <= '0;
      res_r    <= 1'b0;
      idx_r    <= '0;
      best_ok_r <= 1'b0;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (res_r && (!ov_r || !out_stall)) begin
        res_r <= 1'b0;
      end
      if (ctl.load) begin
        req_r     <= in_item;
        idx_r     <= '0;
        best_ok_r <= 1'b0;
      end
      if (ctl.search_start && !sts.search_done) begin
        if (active_r[idx_w] && (!best_ok_r || cnt_r[idx_w] < cnt_r[best_r])) begin
          best_ok_r <= 1'b1;
          best_r    <= idx_w;
        end
        idx_r <= idx_r + SC'(1);
      end
      if (ctl.scan_clear) begin
        idx_r <= '0;
      end
      if (ctl.scan_step) begin
        if (ctl.emit_kill && sts.scan_hit) begin
          drain_r[idx_w]  <= 1'b0;
          online_r[idx_w] <= 1'b0;
        end
        idx_r <= idx_r + SC'(1);
      end
      if (ctl.exec) begin
        res_item_r               <= '0;
        res_item_r.last          <= 1'b1;
        res_item_r.kind          <= KIND_ERROR;
        res_item_r.worker_id_out <= req_r.worker_id;
        case (req_r.command)
          CMD_ONLINE: begin
            if (wok && !online_r[wsel]) begin
              online_r[wsel] <= 1'b1;
              active_r[wsel] <= 1'b1;
              drain_r[wsel]  <= 1'b0;
              cnt_r[wsel]    <= '0;
            end
          end
          CMD_DISPATCH: begin
            res_r <= 1'b1;
            if (!best_ok_r) begin
              res_item_r.error_code <= ERR_NO_WORKER;
            end else if (tvalid_r[ntag_r]) begin
              res_item_r.error_code <= ERR_TAG_BUSY;
              res_item_r.tag_out    <= TAG_W'(ntag_r);
            end else begin
              tvalid_r[ntag_r] <= 1'b1;
              ntag_r <= (ntag_r == TI'(TAG_SLOTS - 1)) ? '0 : ntag_r + TI'(1);
              res_item_r.kind          <= KIND_DISPATCHED;
              res_item_r.worker_id_out <= WID_W'(best_r);
              res_item_r.tag_out       <= TAG_W'(ntag_r);
              res_item_r.client_out    <= cli_masked;
              if (cnt_r[best_r] != CNT_MAX) begin
                cnt_r[best_r]         <= cnt_r[best_r] + QSZ_W'(1);
                res_item_r.queue_size <= cnt_r[best_r] + QSZ_W'(1);
              end else begin
                res_item_r.queue_size <= cnt_r[best_r];
              end
            end
          end
          CMD_COMPLETE: begin
            res_r <= 1'b1;
            if (!rtag_ok || !wok || !tvalid_r[rtag] || rd_owner != req_r.worker_id) begin
              res_item_r.error_code <= ERR_BAD_TAG;
              res_item_r.tag_out    <= req_r.request_tag;
            end else begin
              tvalid_r[rtag] <= 1'b0;
              res_item_r.kind       <= KIND_COMPLETED;
              res_item_r.tag_out    <= req_r.request_tag;
              res_item_r.client_out <= rd_client;
              if (cnt_r[wsel] != '0) begin
                cnt_r[wsel]           <= cnt_r[wsel] - QSZ_W'(1);
                res_item_r.queue_size <= cnt_r[wsel] - QSZ_W'(1);
              end
            end
          end
          CMD_DISABLE: begin
            if (wok && active_r[wsel]) begin
              active_r[wsel] <= 1'b0;
              drain_r[wsel]  <= 1'b1;
            end
          end
          CMD_REBORN: begin
            if (wok && drain_r[wsel]) begin
              drain_r[wsel]  <= 1'b0;
              active_r[wsel] <= 1'b1;
            end else begin
              res_r <= 1'b1;
              res_item_r.error_code <= ERR_BAD_REBORN;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end
endmodule
`default_nettype wire

### design/lld_ctrl.sv
`default_nettype none
module lld_ctrl import lld_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic [CMD_W-1:0] in_command,
  input  wire sts_t     sts,
  output ctl_t          ctl
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !sts.res_pending) begin
          state_nxt = (in_command == CMD_POLL) ? ST_POLL_STAT : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.search_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POLL_STAT: begin
        if (sts.scan_done) begin
          state_nxt = ST_POLL_KILL;
        end
      end
      ST_POLL_KILL: begin
        if (sts.scan_done) begin
          state_nxt = ST_POLL_END;
        end
      end
      ST_POLL_END: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = sts.res_pending;
        ctl.load = in_valid && !sts.res_pending;
      end
      ST_EXEC: begin
        ctl.search_start = 1'b1;
        ctl.exec         = sts.search_done;
      end
      ST_POLL_STAT: begin
        if (sts.scan_done) begin
          ctl.scan_clear = 1'b1;
        end else if (!sts.scan_hit) begin
          ctl.scan_step = 1'b1;
        end else if (sts.out_free) begin
          ctl.emit_stat = 1'b1;
          ctl.scan_step = 1'b1;
        end
      end
      ST_POLL_KILL: begin
        ctl.scan_kill = 1'b1;
        if (!sts.scan_done) begin
          if (!sts.scan_hit) begin
            ctl.scan_step = 1'b1;
          end else if (sts.out_free) begin
            ctl.emit_kill = 1'b1;
            ctl.scan_step = 1'b1;
          end
        end
      end
      ST_POLL_END: begin
        ctl.emit_end = sts.out_free;
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

### design/least_loaded_worker_dispatcher.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | in_item_t (command, ids, tag)
// out_    | output    | out_valid/out_stall| out_item_t (kind .. last)
// Non-poll request: accepted in idle, then the counters are searched and the
//   command executed; any result then moves to the output register.
// Poll: a stat pass and a kill pass, one worker a cycle unless an output stall holds it, then the end marker.
// Reset clears worker state and tag valid bits at once; tag stores need none.
// Output stalls hold the result register, pause the poll walk and hold off input.
`default_nettype none
module least_loaded_worker_dispatcher import lld_pkg::*; #(
  parameter int MAX_WORKERS = 16,
  parameter int TAG_SLOTS   = 256,
  parameter int CLIENT_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);
  ctl_t ctl;
  sts_t sts;
  sts_t sts_c;

  always_comb begin
    sts_c = sts;
  end

  lld_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_item.command), .sts(sts_c), .ctl(ctl)
  );

  lld_datapath #(
    .MAX_WORKERS(MAX_WORKERS), .TAG_SLOTS(TAG_SLOTS), .CLIENT_BITS(CLIENT_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .ctl(ctl), .sts(sts),
    .out_stall(out_stall), .out_valid(out_valid), .out_item(out_item)
  );
endmodule
`default_nettype wire

### tb/least_loaded_worker_dispatcher_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module least_loaded_worker_dispatcher_tb;
  import lld_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  least_loaded_worker_dispatcher uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // dispatcher state mirror
  logic             w_online [16];
  logic             w_active [16];
  logic             w_drain  [16];
  logic [QSZ_W-1:0] w_count  [16];
  logic             t_busy   [256];
  logic [CLI_W-1:0] t_client [256];
  logic [WID_W-1:0] t_owner  [256];
  logic [TAG_W-1:0] tag_next;

  out_item_t expected_q[$];
  int        errors = 0;
  int        phase_idle;
  int        hold_off = 0;
  logic      hold_start = 1'b0;
  logic      hold_done = 1'b0;
  int        sent;

  typedef struct {
    in_item_t  req;
    logic      typed;
    out_item_t res;
  } stim_row_t;
  stim_row_t directed[$];

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void queue_res(input out_item_t r);
    expected_q = {expected_q, r};
  endfunction

  function automatic out_item_t mk(input kind_t k, input logic [3:0] w,
                                   input logic [7:0] t, input logic [15:0] c,
                                   input logic [8:0] q, input err_t e,
                                   input logic l);
    out_item_t r;
    r.kind = k; r.worker_id_out = w; r.tag_out = t; r.client_out = c;
    r.queue_size = q; r.error_code = e; r.last = l;
    return r;
  endfunction

  task automatic predict_request(input in_item_t rq);
    int best;
    logic [7:0] tg;
    logic [3:0] ow;
    best = -1;
    tg = rq.request_tag;
    case (rq.command)
      CMD_ONLINE: if (!w_online[rq.worker_id]) begin
        w_online[rq.worker_id] = 1; w_active[rq.worker_id] = 1;
        w_drain[rq.worker_id] = 0; w_count[rq.worker_id] = 0;
      end
      CMD_DISPATCH: begin
        for (int i = 0; i < 16; i++)
          if (w_active[i] && (best < 0 || w_count[i] < w_count[best])) best = i;
        if (best < 0)
          queue_res(mk(KIND_ERROR, rq.worker_id, 0, 0, 0,
                       ERR_NO_WORKER, 1));
        else if (t_busy[tag_next])
          queue_res(mk(KIND_ERROR, rq.worker_id, tag_next, 0, 0,
                       ERR_TAG_BUSY, 1));
        else begin
          t_busy[tag_next] = 1; t_client[tag_next] = rq.client_id;
          t_owner[tag_next] = best[3:0];
          if (w_count[best] != 9'd511) w_count[best]++;
          queue_res(mk(KIND_DISPATCHED, best[3:0], tag_next,
                       rq.client_id, w_count[best], ERR_NONE, 1));
          tag_next++;
        end
      end
      CMD_COMPLETE: begin
        if (!t_busy[tg] || t_owner[tg] != rq.worker_id)
          queue_res(mk(KIND_ERROR, rq.worker_id, tg, 0, 0,
                       ERR_BAD_TAG, 1));
        else begin
          ow = t_owner[tg];
          t_busy[tg] = 0;
          if (w_count[ow] != 0) w_count[ow]--;
          queue_res(mk(KIND_COMPLETED, ow, tg, t_client[tg],
                       w_count[ow], ERR_NONE, 1));
        end
      end
      CMD_DISABLE: if (w_active[rq.worker_id]) begin
        w_active[rq.worker_id] = 0; w_drain[rq.worker_id] = 1;
      end
      CMD_REBORN:
        if (w_drain[rq.worker_id]) begin
          w_drain[rq.worker_id] = 0; w_active[rq.worker_id] = 1;
        end else
          queue_res(mk(KIND_ERROR, rq.worker_id, 0, 0, 0,
                       ERR_BAD_REBORN, 1));
      CMD_POLL: begin
        for (int i = 0; i < 16; i++)
          if (w_active[i])
            queue_res(mk(KIND_STAT, i[3:0], 0, 0, w_count[i],
                         ERR_NONE, 0));
        for (int i = 0; i < 16; i++)
          if (w_drain[i] && w_count[i] == 0) begin
            queue_res(mk(KIND_KILL, i[3:0], 0, 0, 0, ERR_NONE, 0));
            w_drain[i] = 0; w_online[i] = 0;
          end
        queue_res(mk(KIND_POLL_END, 0, 0, 0, 0, ERR_NONE, 1));
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t req(input logic [2:0] c, input logic [3:0] w,
                                   input logic [15:0] cl, input logic [7:0] t);
    in_item_t r;
    r.command = c; r.worker_id = w; r.client_id = cl; r.request_tag = t;
    return r;
  endfunction

  function automatic logic gap();
    return phase_idle == 0 && $urandom_range(99) < 34;
  endfunction

  // pick a completion that is valid most of the time
  function automatic in_item_t pick_completion();
    logic [7:0] t;
    t = $urandom;
    for (int k = 0; k < 256 && !t_busy[t]; k++) t++;
    if ($urandom_range(9) == 0)
      return req(CMD_COMPLETE, $urandom, $urandom, $urandom);
    if (t_busy[t] && $urandom_range(9) != 0)
      return req(CMD_COMPLETE, t_owner[t], $urandom, t);
    return req(CMD_COMPLETE, $urandom, $urandom, t);
  endfunction

  task automatic send(input in_item_t rq, input logic typed,
                      input out_item_t res);
    while (gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) queue_res(res);
    else predict_request(rq);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_q.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (40) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) report("result with nothing expected");
      else begin
        out_item_t e;
        e = expected_q.pop_front();
        if (out_item.kind != e.kind) report($sformatf("kind %0d exp %0d",
          out_item.kind, e.kind));
        if (out_item.worker_id_out != e.worker_id_out) report($sformatf(
          "worker %0d exp %0d", out_item.worker_id_out, e.worker_id_out));
        if (out_item.tag_out != e.tag_out) report($sformatf("tag %0d exp %0d",
          out_item.tag_out, e.tag_out));
        if (out_item.client_out != e.client_out) report($sformatf(
          "client %0h exp %0h", out_item.client_out, e.client_out));
        if (out_item.queue_size != e.queue_size) report($sformatf(
          "queue %0d exp %0d", out_item.queue_size, e.queue_size));
        if (out_item.error_code != e.error_code) report($sformatf(
          "error %0d exp %0d", out_item.error_code, e.error_code));
        if (out_item.last != e.last) report($sformatf("last %0b exp %0b",
          out_item.last, e.last));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_start && !hold_done) begin
      hold_done <= 1'b1;
      hold_off  <= 300;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else
      out_stall <= rst_n && phase_idle == 0 && $urandom_range(99) < 34;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    in_item_t r;
    int n;
    phase_idle = 0; sent = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_item = '0;
    for (int i = 0; i < 16; i++) begin
      w_online[i] = 0; w_active[i] = 0; w_drain[i] = 0; w_count[i] = 0;
    end
    for (int i = 0; i < 256; i++) begin
      t_busy[i] = 0; t_client[i] = 0; t_owner[i] = 0;
    end
    tag_next = 0;
    // after reset: errors and an empty poll are obvious
    directed.push_front('{req(CMD_POLL, 0, 0, 0), 0, '0});
    directed.push_front('{req(CMD_REBORN, 4'd0, 0, 0), 0, '0});
    directed.push_front('{req(CMD_DISABLE, 4'd0, 0, 0), 0, '0});
    directed.push_front('{req(CMD_ONLINE, 4'd15, 0, 0), 0, '0});
    directed.push_front('{req(CMD_POLL, 0, 0, 0), 0, '0});
    directed.push_front('{req(CMD_DISABLE, 4'd15, 0, 0), 0, '0});
    directed.push_front('{req(CMD_DISABLE, 4'd15, 0, 0), 0, '0});
    directed.push_front('{req(CMD_COMPLETE, 4'd0, 0, 8'd1), 0, '0});
    directed.push_front('{req(CMD_COMPLETE, 4'd0, 0, 8'd1), 0, '0});
    directed.push_front('{req(CMD_COMPLETE, 4'd15, 0, 8'd0), 0, '0});
    directed.push_front('{req(CMD_DISPATCH, 0, 16'h5a5a, 0), 0, '0});
    directed.push_front('{req(CMD_DISPATCH, 0, 16'hffff, 0), 0, '0});
    directed.push_front('{req(CMD_DISPATCH, 0, 16'h0000, 0), 0, '0});
    directed.push_front('{req(CMD_ONLINE, 4'd0, 0, 0), 0, '0});
    directed.push_front('{req(CMD_ONLINE, 4'd0, 0, 0), 0, '0});
    directed.push_front('{req(CMD_ONLINE, 4'd15, 0, 0), 0, '0});
    directed.push_front('{req(3'd7, 4'd2, 0, 0), 0, '0});
    directed.push_front('{req(3'd6, 4'd1, 0, 0), 0, '0});
    directed.push_front('{req(CMD_POLL, 0, 0, 0), 1,
      mk(KIND_POLL_END, 0, 0, 0, 0, ERR_NONE, 1)});
    directed.push_front('{req(CMD_REBORN, 4'd3, 0, 0), 1,
      mk(KIND_ERROR, 3, 0, 0, 0, ERR_BAD_REBORN, 1)});
    directed.push_front('{req(CMD_COMPLETE, 4'd0, 0, 8'd255), 1,
      mk(KIND_ERROR, 0, 255, 0, 0, ERR_BAD_TAG, 1)});
    directed.push_front('{req(CMD_DISPATCH, 4'd15, 16'hffff, 0), 1,
      mk(KIND_ERROR, 15, 0, 0, 0, ERR_NO_WORKER, 1)});
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (directed[i]) send(directed[i].req, directed[i].typed, directed[i].res);
    wait_drained();
    for (int i = 1; i < 15; i++) send(req(CMD_ONLINE, i[3:0], 0, 0), 0, '0);
    // drive a random mix of dispatches, completions and other requests
    n = 0;
    while (n < 334) begin
      if (n == 120) begin
        phase_idle = 1;
        hold_start = 1'b1;
      end
      if (n == 200) phase_idle = 0;
      if (n == 250) wait_drained();
      case ($urandom_range(99)) inside
        [0:44]:  r = req(CMD_DISPATCH, $urandom, $urandom, $urandom);
        [45:79]: r = pick_completion();
        [80:85]: r = req(CMD_DISABLE, $urandom, $urandom, $urandom);
        [86:89]: r = req(CMD_REBORN, $urandom, $urandom, $urandom);
        [90:93]: r = req(CMD_ONLINE, $urandom, $urandom, $urandom);
        [94:97]: r = req(CMD_POLL, $urandom, $urandom, $urandom);
        default: r = req($urandom_range(7), $urandom, $urandom, $urandom);
      endcase
      send(r, 0, '0);
      n++;
    end
    wait_drained();
    if (errors == 0 && expected_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

### least_loaded_worker_dispatcher.f
design/lld_pkg.sv
design/lld_ram.sv
design/lld_datapath.sv
design/lld_ctrl.sv
design/least_loaded_worker_dispatcher.sv
tb/least_loaded_worker_dispatcher_tb.sv
